// ===== hdl/nan_masked_fir_normalized_top_defines.svh =====
// assertion macros used by nmf_ctrl
`ifndef NAN_MASKED_FIR_NORMALIZED_TOP_DEFINES_SVH
`define NAN_MASKED_FIR_NORMALIZED_TOP_DEFINES_SVH

// property must hold on every edge outside reset
`define NMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next edge
`define NMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nmf_pkg.sv =====
// ----------------------------------------------------------------------------
// nmf_pkg
// types, constants and register codes of the normalized masked fir
// ----------------------------------------------------------------------------
package nmf_pkg;

  localparam int MAX_HALF_D    = 8;
  localparam int MAX_STEP_D    = 4;
  localparam int SAMPLE_BITS_D = 16;
  localparam int COEF_BITS_D   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int CNT_BITS      = 7;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 7'd127;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_HALF = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_STEP  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ADDR = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_DATA = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_CHECK,
    ST_TAP,
    ST_DIV,
    ST_OUT
  } nmf_state_t;

  // controller to datapath
  typedef struct packed {
    logic push;       // shift the accepted sample into the window
    logic start_emit; // load the centre sample, start an output
    logic tap_step;   // run one tap of the accumulate
    logic div_start;  // start the divider
    logic div_step;   // one quotient bit
    logic load_out;   // write the result register
  } nmf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic taps_done;
    logic div_done;
  } nmf_sts_t;

endpackage

// ===== hdl/nmf_if.sv =====
// ----------------------------------------------------------------------------
// nmf_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface nmf_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/nmf_ram.sv =====
// ----------------------------------------------------------------------------
// nmf_ram
// generic simple dual-port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module nmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/nmf_datapath.sv =====
// ----------------------------------------------------------------------------
// nmf_datapath
// sample window, tap table, shared multiply-accumulate and serial divider
// ----------------------------------------------------------------------------
module nmf_datapath #(
  parameter int MAX_HALF    = nmf_pkg::MAX_HALF_D,
  parameter int MAX_STEP    = nmf_pkg::MAX_STEP_D,
  parameter int SAMPLE_BITS = nmf_pkg::SAMPLE_BITS_D,
  parameter int COEF_BITS   = nmf_pkg::COEF_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nmf_pkg::nmf_cmd_t                  cmd,
  output nmf_pkg::nmf_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [nmf_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [nmf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]      in_value,
  input  logic                               in_ok,
  input  logic [$clog2(2*MAX_HALF*MAX_STEP+2)-1:0] centre_d,
  input  logic [nmf_pkg::CNT_BITS-1:0]       emitted,
  output logic [$clog2(2*MAX_HALF*MAX_STEP+2)-1:0] lag,
  output logic signed [SAMPLE_BITS-1:0]      res_value,
  output logic                               res_invalid,
  output logic                               res_zero
);
  import nmf_pkg::*;

  localparam int WIN_DEPTH = 2*MAX_HALF*MAX_STEP + 1;
  localparam int TAP_DEPTH = 2*MAX_HALF + 1;
  localparam int WAW       = $clog2(WIN_DEPTH);
  localparam int DW        = $clog2(WIN_DEPTH + 1);
  localparam int HW        = $clog2(MAX_HALF + 1);
  localparam int SW        = $clog2(MAX_STEP + 1);
  localparam int TW        = $clog2(TAP_DEPTH + 1);
  localparam int PW        = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PW + TW;
  localparam int DEN_BITS  = COEF_BITS + TW;
  localparam int QB        = ACC_BITS;
  localparam int DCW       = $clog2(QB + 1);

  // configuration registers
  logic [3:0] taps_half_r;
  logic [2:0] tap_step_r;
  logic [4:0] coef_addr_r;
  logic [TAP_DEPTH-1:0]        tap_ok_r;
  logic signed [COEF_BITS-1:0] coef_r [TAP_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_half_r <= 4'd1;
      tap_step_r  <= 3'd1;
      coef_addr_r <= '0;
      tap_ok_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TAPS_HALF: taps_half_r <= cfg_data[3:0];
        REG_TAP_STEP:  tap_step_r  <= cfg_data[2:0];
        REG_COEF_ADDR: coef_addr_r <= cfg_data[4:0];
        REG_COEF_DATA: begin
          if (32'(coef_addr_r) < TAP_DEPTH) begin
            tap_ok_r[coef_addr_r[TW-1:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we && cfg_idx == REG_COEF_DATA && 32'(coef_addr_r) < TAP_DEPTH) begin
      coef_r[coef_addr_r[TW-1:0]] <= COEF_BITS'($signed(cfg_data));
    end
  end

  // clamped half-width and step
  logic [HW-1:0] half;
  logic [SW-1:0] step;
  always_comb begin
    half = (32'(taps_half_r) > MAX_HALF) ? HW'(MAX_HALF) : HW'(taps_half_r);
    if (tap_step_r == 3'd0) begin
      step = SW'(1);
    end else if (32'(tap_step_r) > MAX_STEP) begin
      step = SW'(MAX_STEP);
    end else begin
      step = SW'(tap_step_r);
    end
  end
  assign lag = DW'(32'(half) * 32'(step));

  // sample window: ring buffer in ram, head points at the newest entry
  logic [WAW-1:0] head_r;
  logic [WAW-1:0] raddr;
  logic [SAMPLE_BITS:0] rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (cmd.push) begin
      head_r <= (32'(head_r) == WIN_DEPTH - 1) ? '0 : head_r + 1'b1;
    end
  end

  nmf_ram #(.WIDTH(SAMPLE_BITS + 1), .DEPTH(WIN_DEPTH)) u_win (
    .clk   (clk),
    .we    (cmd.push),
    .waddr ((32'(head_r) == WIN_DEPTH - 1) ? WAW'(0) : WAW'(head_r + 1'b1)),
    .wdata ({in_ok, in_value}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // tap walk: k runs 0..2h, distance = d - (k-h)*step
  logic [TW-1:0]  k_r;
  logic           rd_pend_r;
  logic           use_pend_r;
  logic           centre_pend_r;
  logic signed [ACC_BITS-1:0] num_r;
  logic signed [DEN_BITS-1:0] den_r;
  logic           centre_ok_r;

  logic signed [DW+1:0] tap_d;
  logic                 tap_use;
  always_comb begin
    tap_d = $signed({2'b00, centre_d})
          - $signed((DW+2)'((32'(k_r) - 32'(half)) * 32'(step)));
    tap_use = 1'b1;
    if (tap_d < 0 || tap_d >= WIN_DEPTH) begin
      tap_use = 1'b0;
    end else if (tap_d > $signed({2'b00, centre_d}) &&
                 32'(tap_d - $signed({2'b00, centre_d})) > 32'(emitted)) begin
      tap_use = 1'b0;
    end
  end

  // address of a distance back from head
  function automatic logic [WAW-1:0] back_addr(input logic [WAW-1:0] hd,
                                               input logic [DW-1:0] dd);
    logic [WAW+1:0] t;
    begin
      t = {2'b00, hd} + (WAW+2)'(WIN_DEPTH) - (WAW+2)'(dd);
      if (32'(t) >= WIN_DEPTH) t = t - (WAW+2)'(WIN_DEPTH);
      back_addr = t[WAW-1:0];
    end
  endfunction

  always_comb begin
    if (cmd.start_emit) begin
      raddr = back_addr(head_r, (32'(centre_d) < WIN_DEPTH) ? centre_d : DW'(0));
    end else begin
      raddr = back_addr(head_r, tap_use ? DW'(tap_d) : DW'(0));
    end
  end

  // one product a cycle, registered before the accumulate
  logic signed [PW-1:0] prod_r;
  logic signed [COEF_BITS-1:0] coef_pend_r;
  logic prod_v_r;
  logic signed [COEF_BITS-1:0] coef_k;
  assign coef_k = tap_ok_r[k_r] ? coef_r[k_r] : '0;

  // a tap is issued only while k is inside the filter
  logic tap_go;
  assign tap_go = cmd.tap_step && (32'(k_r) <= 2 * 32'(half));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r     <= 1'b0;
      centre_pend_r <= 1'b0;
      prod_v_r      <= 1'b0;
      k_r           <= '0;
      centre_ok_r   <= 1'b0;
      num_r         <= '0;
      den_r         <= '0;
    end else begin
      centre_pend_r <= cmd.start_emit;
      rd_pend_r     <= tap_go;
      use_pend_r    <= tap_use;
      coef_pend_r   <= coef_k;
      prod_v_r      <= 1'b0;
      if (cmd.start_emit) begin
        k_r   <= '0;
        num_r <= '0;
        den_r <= '0;
      end else if (tap_go) begin
        k_r <= k_r + 1'b1;
      end
      if (centre_pend_r) begin
        centre_ok_r <= rdata[SAMPLE_BITS] && (32'(centre_d) < WIN_DEPTH);
      end
      if (rd_pend_r && use_pend_r && rdata[SAMPLE_BITS]) begin
        prod_r   <= PW'(coef_pend_r * $signed(rdata[SAMPLE_BITS-1:0]));
        prod_v_r <= 1'b1;
        den_r    <= den_r + DEN_BITS'(coef_pend_r);
      end
      if (prod_v_r) begin
        num_r <= num_r + ACC_BITS'(prod_r);
      end
    end
  end

  assign sts.taps_done = (32'(k_r) > 2 * 32'(half)) && !rd_pend_r && !prod_v_r;

  // restoring divider on magnitudes, one quotient bit a step
  logic [QB-1:0]   dq_r;
  logic [QB:0]     rem_r;
  logic [QB-1:0]   dvs_r;
  logic            neg_r;
  logic [DCW-1:0]  dcnt_r;
  logic [QB:0]     trial;
  assign trial = {rem_r[QB-1:0], dq_r[QB-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dq_r   <= num_r[ACC_BITS-1] ? QB'(-num_r) : QB'(num_r);
      dvs_r  <= den_r[DEN_BITS-1] ? QB'(-den_r) : QB'(den_r);
      neg_r  <= num_r[ACC_BITS-1] ^ den_r[DEN_BITS-1];
      rem_r  <= '0;
      dcnt_r <= DCW'(QB);
    end else if (cmd.div_step && dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (!trial[QB]) begin
        rem_r <= trial;
        dq_r  <= {dq_r[QB-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[QB-1:0], dq_r[QB-1]};
        dq_r  <= {dq_r[QB-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (dcnt_r == '0);

  // saturate the signed quotient
  localparam logic [QB-1:0] HI_MAG = QB'((64'd1 << (SAMPLE_BITS-1)) - 1);
  logic signed [SAMPLE_BITS-1:0] sat;
  always_comb begin
    if (!neg_r) begin
      sat = (dq_r > HI_MAG) ? SAMPLE_BITS'(HI_MAG) : SAMPLE_BITS'(dq_r);
    end else begin
      sat = (dq_r > HI_MAG) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : -SAMPLE_BITS'(dq_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_invalid <= !centre_ok_r;
      res_zero    <= centre_ok_r && (den_r == '0);
      res_value   <= (!centre_ok_r || den_r == '0) ? '0 : sat;
    end
  end
endmodule

// ===== hdl/nmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// nmf_ctrl
// sequencer: accept, emit loop, tap walk, divide, result handoff
// ----------------------------------------------------------------------------
`include "nan_masked_fir_normalized_top_defines.svh"
module nmf_ctrl #(
  parameter int DW = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_last,
  output nmf_pkg::nmf_cmd_t            cmd,
  input  nmf_pkg::nmf_sts_t            sts,
  input  logic [DW-1:0]                lag,
  output logic [DW-1:0]                centre_d,
  output logic [nmf_pkg::CNT_BITS-1:0] emitted
);
  import nmf_pkg::*;

  nmf_state_t state_r, state_nxt;
  logic [DW-1:0] pend_r, pend_nxt;
  logic [CNT_BITS-1:0] emit_r, emit_nxt;
  logic flush_r, flush_nxt;
  logic ov_r, ov_nxt;
  logic ol_r, ol_nxt;
  logic div_first_r, div_first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      emit_r      <= '0;
      flush_r     <= 1'b0;
      ov_r        <= 1'b0;
      ol_r        <= 1'b0;
      div_first_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      emit_r      <= emit_nxt;
      flush_r     <= flush_nxt;
      ov_r        <= ov_nxt;
      ol_r        <= ol_nxt;
      div_first_r <= div_first_nxt;
    end
  end

  assign centre_d  = pend_r - 1'b1;
  assign emitted   = emit_r;
  assign out_valid = ov_r;
  assign out_last  = ol_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    emit_nxt      = emit_r;
    flush_nxt     = flush_r;
    ov_nxt        = ov_r;
    ol_nxt        = ol_r;
    div_first_nxt = 1'b0;
    cmd           = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.push  = 1'b1;
          pend_nxt  = pend_r + 1'b1;
          flush_nxt = in_last;
          state_nxt = ST_EMIT_CHECK;
        end
      end
      ST_EMIT_CHECK: begin
        if ((flush_r && pend_r != '0) || (!flush_r && pend_r > lag)) begin
          cmd.start_emit = 1'b1;
          state_nxt      = ST_TAP;
        end else begin
          if (flush_r) begin
            pend_nxt = '0;
            emit_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_TAP: begin
        if (sts.taps_done) begin
          cmd.div_start = 1'b1;
          div_first_nxt = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.tap_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts.div_done && !div_first_r) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!ov_nxt) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          ol_nxt       = flush_r && pend_r == DW'(1);
          pend_nxt     = pend_r - 1'b1;
          if (emit_r != CNT_MAX) emit_nxt = emit_r + 1'b1;
          state_nxt    = ST_EMIT_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `NMF_ASSERT(a_ready_idle, !(in_ready && state_r != ST_IDLE), "ready outside idle")
  `NMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `NMF_ASSERT_NEXT(a_load_once, cmd.load_out, !cmd.load_out, "double load")
endmodule

// ===== hdl/nan_masked_fir_normalized_top.sv =====
// samples are taken only while idle, so none is accepted while a result is computed
// the shared multiply-accumulate walk and the serial divider set the rate
// reset: synchronous active low; taps_half 1, tap_step 1, tap table zero
// ----------------------------------------------------------------------------
// nan_masked_fir_normalized_top
// normalized fir with missing-sample masking over lines of samples
// ----------------------------------------------------------------------------
module nan_masked_fir_normalized_top #(
  parameter int MAX_HALF    = nmf_pkg::MAX_HALF_D,
  parameter int MAX_STEP    = nmf_pkg::MAX_STEP_D,
  parameter int SAMPLE_BITS = nmf_pkg::SAMPLE_BITS_D,
  parameter int COEF_BITS   = nmf_pkg::COEF_BITS_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_value,
  input  logic                              in_sample_valid,
  input  logic                              in_last_in_line,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_filtered_value,
  output logic                              out_out_invalid,
  output logic                              out_zero_weight,
  output logic                              out_line_done,
  input  logic                              cfg_we,
  input  logic [nmf_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [nmf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import nmf_pkg::*;

  localparam int DW = $clog2(2*MAX_HALF*MAX_STEP + 2);

  nmf_cmd_t cmd;
  nmf_sts_t sts;
  logic [DW-1:0] lag;
  logic [DW-1:0] centre_d;
  logic [CNT_BITS-1:0] emitted;

  // controller
  nmf_ctrl #(.DW(DW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last_in_line),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_line_done),
    .cmd       (cmd),
    .sts       (sts),
    .lag       (lag),
    .centre_d  (centre_d),
    .emitted   (emitted)
  );

  // datapath
  nmf_datapath #(
    .MAX_HALF(MAX_HALF), .MAX_STEP(MAX_STEP),
    .SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_value    (in_sample_value),
    .in_ok       (in_sample_valid),
    .centre_d    (centre_d),
    .emitted     (emitted),
    .lag         (lag),
    .res_value   (out_filtered_value),
    .res_invalid (out_out_invalid),
    .res_zero    (out_zero_weight)
  );
endmodule

// ===== tb/nan_masked_fir_normalized_top_tb.sv =====
// ----------------------------------------------------------------------------
// nan_masked_fir_normalized_top_tb
// Self-checking bench for the masked normalized FIR. A queue-fed driver sends
// lines of samples, and a software line window predicts every output. A
// monitor compares each output field by field. The bench steps through tap
// widths, steps and coefficient sets, with random gaps on both channels.
// ----------------------------------------------------------------------------
module nan_masked_fir_normalized_top_tb;
  import nmf_pkg::*;

  localparam int WIN_LEN    = 2 * MAX_HALF_D * MAX_STEP_D + 1;
  localparam int TAP_LEN    = 2 * MAX_HALF_D + 1;
  localparam int DRAIN_WAIT = 120;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] value;
    logic               ok;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               invalid;
    logic               zero_wt;
    logic               done;
  } filt_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  nmf_if #(.payload_t(sample_t)) in_ch ();
  nmf_if #(.payload_t(filt_t))   out_ch ();

  nan_masked_fir_normalized_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_sample_value    (in_ch.data.value),
    .in_sample_valid    (in_ch.data.ok),
    .in_last_in_line    (in_ch.data.last),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_filtered_value (out_ch.data.value),
    .out_out_invalid    (out_ch.data.invalid),
    .out_zero_weight    (out_ch.data.zero_wt),
    .out_line_done      (out_ch.data.done),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_data           (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // filter mirror state
  logic [3:0]         half_r;
  logic [2:0]         step_r;
  logic [4:0]         addr_r;
  logic signed [15:0] coef_tab [TAP_LEN];
  logic signed [15:0] win_val  [WIN_LEN];
  logic               win_ok   [WIN_LEN];
  int                 rcvd_cnt;
  int                 emit_cnt;
  int                 backlog;

  sample_t sample_q [$];
  filt_t   filt_q   [$];
  int      mismatches;
  int      stall_cnt;
  bit      calm;
  int      n_items;

  function automatic int eff_half();
    return (half_r > MAX_HALF_D) ? MAX_HALF_D : int'(half_r);
  endfunction

  function automatic int eff_step();
    if (step_r == 3'd0) return 1;
    return (step_r > MAX_STEP_D) ? MAX_STEP_D : int'(step_r);
  endfunction

  // one output for the oldest sample still waiting
  function automatic void emit_filtered(bit done);
    int d;
    int h;
    int st;
    int offs;
    longint num;
    longint den;
    longint q;
    filt_t r;
    d = backlog - 1;
    h = eff_half();
    st = eff_step();
    num = 0;
    den = 0;
    q = 0;
    r = '0;
    if (d < 0 || d >= WIN_LEN || !win_ok[d]) begin
      r.invalid = 1'b1;
    end else begin
      for (int k = -h; k <= h; k++) begin
        offs = d - k * st;
        if (offs < 0 || offs >= WIN_LEN) continue;
        if (offs > d && (offs - d) > emit_cnt) continue;
        if (!win_ok[offs]) continue;
        num += longint'(coef_tab[k + h]) * longint'(win_val[offs]);
        den += longint'(coef_tab[k + h]);
      end
      if (den == 0) begin
        r.zero_wt = 1'b1;
      end else begin
        q = num / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
    end
    r.value = q[15:0];
    r.done = done;
    filt_q.push_back(r);
    if (backlog > 0) backlog--;
    if (emit_cnt < 127) emit_cnt++;
  endfunction

  // shift one accepted sample in and predict what it releases
  function automatic void predict_sample(sample_t s);
    int lag;
    lag = eff_half() * eff_step();
    for (int i = WIN_LEN - 1; i > 0; i--) begin
      win_val[i] = win_val[i-1];
      win_ok[i] = win_ok[i-1];
    end
    win_val[0] = s.value;
    win_ok[0] = s.ok;
    if (rcvd_cnt < 127) rcvd_cnt++;
    backlog++;
    if (s.last) begin
      while (backlog > 0) emit_filtered(backlog == 1);
      rcvd_cnt = 0;
      emit_cnt = 0;
      backlog = 0;
    end else begin
      while (backlog > lag) emit_filtered(1'b0);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_sample(in_ch.data);
      if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= sample_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    filt_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 17);
      if (out_ch.valid && out_ch.ready) begin
        if (filt_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transfer: %p", out_ch.data);
        end else begin
          exp_r = filt_q.pop_front();
          if (out_ch.data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output mismatch: exp val %0d inv %b zw %b done %b, got val %0d inv %b zw %b done %b",
                       exp_r.value, exp_r.invalid, exp_r.zero_wt, exp_r.done,
                       out_ch.data.value, out_ch.data.invalid, out_ch.data.zero_wt,
                       out_ch.data.done);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // register write, mirrored into the predictor
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_TAPS_HALF: half_r = val[3:0];
      REG_TAP_STEP:  step_r = val[2:0];
      REG_COEF_ADDR: addr_r = val[4:0];
      REG_COEF_DATA: if (addr_r < TAP_LEN) coef_tab[addr_r] = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coef(int a, logic [15:0] val);
    write_reg(REG_COEF_ADDR, 16'(a));
    write_reg(REG_COEF_DATA, val);
  endtask

  // random coefficient set, mostly positive weights
  task automatic random_coefs();
    logic [15:0] c;
    for (int a = 0; a < TAP_LEN; a++) begin
      case ($urandom_range(5))
        0: c = 16'($urandom);
        1: c = 16'h0000;
        2: c = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        default: c = 16'($urandom_range(16384));
      endcase
      set_coef(a, c);
    end
  endtask

  task automatic queue_line(int len, int miss_pct, bit close);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: s.value = 16'sh7fff;
        1: s.value = -16'sh8000;
        default: s.value = 16'($urandom);
      endcase
      s.ok = ($urandom_range(99) >= miss_pct);
      s.last = close && (i == len - 1);
      sample_q.push_back(s);
      n_items++;
    end
  endtask

  task automatic push_sample(logic signed [15:0] v, logic ok, logic last);
    sample_t s;
    s.value = v;
    s.ok = ok;
    s.last = last;
    sample_q.push_back(s);
    n_items++;
  endtask

  // wait until nothing is in flight, then let trailing work settle
  task automatic drain();
    while (sample_q.size() > 0 || in_ch.valid || filt_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    mismatches = 0;
    calm = 1'b0;
    n_items = 0;
    half_r = 4'd1;
    step_r = 3'd1;
    addr_r = 5'd0;
    rcvd_cnt = 0;
    emit_cnt = 0;
    backlog = 0;
    for (int i = 0; i < TAP_LEN; i++) coef_tab[i] = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      win_val[i] = '0;
      win_ok[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset taps are all zero, so every valid centre has zero weight
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(-16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh0000, 1'b0, 1'b0);
    push_sample(16'sh0001, 1'b1, 1'b1);
    drain();

    // three-tap smoother, single-sample line, missing samples
    write_reg(REG_TAPS_HALF, 16'd1);
    write_reg(REG_TAP_STEP, 16'd1);
    set_coef(0, 16'd4096);
    set_coef(1, 16'd8192);
    set_coef(2, 16'd4096);
    end_writes();
    push_sample(-16'sh1234, 1'b1, 1'b1);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh7fff, 1'b0, 1'b0);
    push_sample(-16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh0100, 1'b1, 1'b1);
    drain();

    // widest filter with extreme coefficients, causing saturation
    write_reg(REG_TAPS_HALF, 16'd8);
    write_reg(REG_TAP_STEP, 16'd4);
    for (int a = 0; a < TAP_LEN; a++) set_coef(a, (a % 2) ? 16'h8000 : 16'h7fff);
    set_coef(8, 16'h0001);
    end_writes();
    queue_line(8, 20, 1'b1);
    drain();

    // out-of-range half and step clamp, out-of-range coefficient address ignored
    write_reg(REG_TAPS_HALF, 16'hffff);
    write_reg(REG_TAP_STEP, 16'd0);
    set_coef(17, 16'h5555);
    set_coef(31, 16'haaaa);
    end_writes();
    queue_line(6, 10, 1'b1);
    drain();
    write_reg(REG_TAPS_HALF, 16'd0);
    write_reg(REG_TAP_STEP, 16'd7);
    end_writes();
    queue_line(3, 30, 1'b0);
    drain();

    // random phases; one runs without any gaps
    for (int ph = 0; ph < 3 || n_items < 80; ph++) begin
      calm = (ph == 2);
      if (ph == 0) begin
        write_reg(REG_TAPS_HALF, 16'd2);
        write_reg(REG_TAP_STEP, 16'd2);
      end else begin
        write_reg(REG_TAPS_HALF, 16'($urandom_range(15)));
        write_reg(REG_TAP_STEP, 16'($urandom_range(7)));
      end
      if ($urandom_range(2) != 0 || ph == 0) random_coefs();
      end_writes();
      // one longer line
      if (ph == 0) queue_line(30, 15, 1'b1);
      for (int l = $urandom_range(3, 1); l > 0; l--)
        queue_line($urandom_range(12, 1), 20, 1'b1);
      // leave a line open so the next setting changes taps mid-line
      if ($urandom_range(2) == 0) queue_line($urandom_range(12, 1), 20, 1'b0);
      drain();
    end
    calm = 1'b0;
    queue_line(5, 20, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== nan_masked_fir_normalized_top.f =====
+incdir+hdl
hdl/nmf_pkg.sv
hdl/nmf_if.sv
hdl/nmf_ram.sv
hdl/nmf_datapath.sv
hdl/nmf_ctrl.sv
hdl/nan_masked_fir_normalized_top.sv
tb/nan_masked_fir_normalized_top_tb.sv
